// ===== sv/tdp_pkg.sv =====
// Shared constants and sequencer state type for the trial-division prime tester.
package tdp_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 31;
  localparam int unsigned FIRST_DIVISOR   = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_DONE
  } tdp_state_e;

endpackage

// ===== sv/tdp_if.sv =====
// Handshake interfaces for the candidate word and the result word.
interface tdp_cand_if #(
  parameter int unsigned ValueWidth = 31
);
  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== sv/trial_division_prime_test.sv =====
// Top level of the trial-division prime tester.
//
//   port    dir  word        width
//   cand_i  in   candidate   ValueWidth
//   res_o   out  is_prime    1
//
// Each accepted item runs D divisions, D being at most floor(sqrt(candidate)) (the last
// one may only find the divisor past the root); each takes ValueWidth divider steps and a
// check, which restarts the divider with the next divisor unless the search ends. Candidates
// below two run no division. Reset clears the control state.
// cand_i is ready only while idle; a result waiting on res_o holds the next one in DONE.
module trial_division_prime_test
  import tdp_pkg::*;
#(
  parameter int unsigned ValueWidth = VALUE_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tdp_cand_if.sink cand_i,
  tdp_res_if.source res_o
);

  logic                  div_start;
  logic                  div_done;
  logic [ValueWidth-1:0] div_dividend;
  logic [ValueWidth-1:0] div_divisor;
  logic [ValueWidth-1:0] div_quotient;
  logic [ValueWidth-1:0] div_remainder;

  tdp_div #(
    .ValueWidth(ValueWidth)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient),
    .remainder_o(div_remainder)
  );

  tdp_seq #(
    .ValueWidth(ValueWidth)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cand_valid_i   (cand_i.valid),
    .cand_i         (cand_i.candidate),
    .cand_ready_o   (cand_i.ready),
    .res_valid_o    (res_o.valid),
    .res_o          (res_o.is_prime),
    .res_ready_i    (res_o.ready),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quotient_i (div_quotient),
    .div_remainder_i(div_remainder)
  );

endmodule

// ===== sv/tdp_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module tdp_div
  import tdp_pkg::*;
#(
  parameter int unsigned ValueWidth = VALUE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ValueWidth-1:0] dividend_i,
  input  logic [ValueWidth-1:0] divisor_i,
  output logic                  done_o,
  output logic [ValueWidth-1:0] quotient_o,
  output logic [ValueWidth-1:0] remainder_o
);

  localparam int unsigned CntWidth = $clog2(ValueWidth);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(ValueWidth - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [ValueWidth-1:0] quo_q, quo_d;
  logic [ValueWidth-1:0] rem_q, rem_d;
  logic [ValueWidth-1:0] dvs_q, dvs_d;
  logic [ValueWidth:0]   partial;
  logic [ValueWidth:0]   diff;
  logic                  fits;

  assign partial = {rem_q, quo_q[ValueWidth-1]};
  assign diff    = partial - {1'b0, dvs_q};
  assign fits    = partial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[ValueWidth-2:0], fits};
      rem_d = fits ? diff[ValueWidth-1:0] : partial[ValueWidth-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== sv/tdp_seq.sv =====
// Sequencer: steps the trial divisor, judges each division, holds the result word.
module tdp_seq
  import tdp_pkg::*;
#(
  parameter int unsigned ValueWidth = VALUE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cand_valid_i,
  input  logic [ValueWidth-1:0] cand_i,
  output logic                  cand_ready_o,
  output logic                  res_valid_o,
  output logic                  res_o,
  input  logic                  res_ready_i,
  output logic                  div_start_o,
  output logic [ValueWidth-1:0] div_dividend_o,
  output logic [ValueWidth-1:0] div_divisor_o,
  input  logic                  div_done_i,
  input  logic [ValueWidth-1:0] div_quotient_i,
  input  logic [ValueWidth-1:0] div_remainder_i
);

  localparam logic [ValueWidth-1:0] FirstDiv = ValueWidth'(FIRST_DIVISOR);

  tdp_state_e state_q, state_d;

  logic [ValueWidth-1:0] n_q, d_q;
  logic                  verdict_q;
  logic                  res_valid_q, res_valid_d;
  logic                  res_q;

  logic accept, below_two, past_root, divides, load_res;

  assign accept    = cand_valid_i && cand_ready_o;
  assign below_two = cand_i < FirstDiv;
  assign past_root = d_q > div_quotient_i;
  assign divides   = div_remainder_i == '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = below_two ? ST_DONE : ST_DIV;
      ST_DIV:   if (div_done_i) state_d = ST_CHECK;
      ST_CHECK: state_d = (past_root || divides) ? ST_DONE : ST_DIV;
      ST_DONE:  if (load_res) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cand_ready_o = state_q == ST_IDLE;
    load_res     = (state_q == ST_DONE) && (!res_valid_q || res_ready_i);
    div_start_o  = 1'b0;
    unique case (state_q)
      ST_IDLE:  div_start_o = accept && !below_two;
      ST_CHECK: div_start_o = !past_root && !divides;
      default:  div_start_o = 1'b0;
    endcase
  end

  assign div_dividend_o = (state_q == ST_IDLE) ? cand_i : n_q;
  assign div_divisor_o  = (state_q == ST_IDLE) ? FirstDiv : d_q + 1'b1;

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_ready_i) res_valid_d = 1'b0;
    if (load_res) res_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q       <= cand_i;
      d_q       <= FirstDiv;
      verdict_q <= 1'b0;
    end else if (state_q == ST_CHECK) begin
      if (past_root) begin
        verdict_q <= 1'b1;
      end else if (divides) begin
        verdict_q <= 1'b0;
      end else begin
        d_q <= d_q + 1'b1;
      end
    end
    if (load_res) res_q <= verdict_q;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
